// ===== sv/sc2a_pkg.sv =====
// Shared constants, types and key tables for the scancode-to-ASCII queue.
`default_nettype none

package sc2a_pkg;

    localparam int QUEUE_SIZE = 64;
    localparam int PTR_W      = $clog2(QUEUE_SIZE);
    localparam int CHAR_W     = 7;
    localparam int CODE_W     = 7;
    localparam int TABLE_LEN  = 58;
    localparam int TAB_IDX_W  = $clog2(TABLE_LEN);

    localparam logic [CODE_W-1:0] SC_SHIFT_L   = 7'h2A;
    localparam logic [CODE_W-1:0] SC_SHIFT_R   = 7'h36;
    localparam logic [CODE_W-1:0] SC_CTRL      = 7'h1D;
    localparam logic [CODE_W-1:0] SC_ALT       = 7'h38;
    localparam logic [CODE_W-1:0] SC_CAPS_LOCK = 7'h3A;

    localparam logic OP_SCANCODE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [CHAR_W-1:0] PLAIN_TAB [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A,
        7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        7'h3B, 7'h27, 7'h60,
        7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] UPPER_TAB [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
        7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
        7'h50, 7'h7B, 7'h7D, 7'h0A,
        7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
        7'h3A, 7'h22, 7'h7E,
        7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } t_mods;

    typedef struct packed {
        t_mods             mods;
        logic              push;
        logic [CHAR_W-1:0] ch;
    } t_key_upd;

    // Map a key code to its character; codes past the table give zero.
    function automatic logic [CHAR_W-1:0] key_char(input logic [CODE_W-1:0] code,
                                                   input logic upper);
        logic [TAB_IDX_W-1:0] idx;
        idx = code[TAB_IDX_W-1:0];
        if (code >= CODE_W'(TABLE_LEN)) begin
            return '0;
        end
        return upper ? UPPER_TAB[idx] : PLAIN_TAB[idx];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/scancode_to_ascii_fifo_core.sv =====
// Top level: set-1 scancode decoder feeding a character queue held in a RAM.
// Throughput: one word per cycle while the output is not stalled; the queue RAM
// takes one write or one read per word, and its read data is registered.
// Reset (synchronous, active low) clears modifier flags, queue pointers and
// pipeline valids; queue contents are not cleared.
`default_nettype none

module scancode_to_ascii_fifo_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] scancode
    input  wire logic [0:0]  i_s_tuser,   // [0] opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [6:0] character, [7] queue_nonempty,
                                          // [8] shift_held, [9] ctrl_held,
                                          // [10] alt_held, [15:11] zero
    output logic [0:0]       o_m_tuser    // [0] char_valid
);
    import sc2a_pkg::*;

    logic [CHAR_W-1:0] r_store [QUEUE_SIZE];

    t_mods             r_mods, n_mods;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    t_key_upd          upd;

    logic              accept;
    logic              is_read;
    logic              do_pop;
    logic              do_push;
    logic              s1_adv;

    logic              r_s1_valid;
    logic              r_s1_pop;
    logic              r_s1_nonempty;
    t_mods             r_s1_mods;
    logic [CHAR_W-1:0] r_rd_data;

    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic              r_out_user;

    sc2a_keymap u_keymap (
        .i_scancode (i_s_tdata),
        .i_mods     (r_mods),
        .o_upd      (upd)
    );

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_read    = (i_s_tuser[0] == OP_READ);

    assign do_pop  = is_read && (r_rptr != r_wptr);
    assign do_push = !is_read && upd.push && (ptr_inc(r_wptr) != r_rptr);

    always_comb begin
        n_mods = r_mods;
        n_rptr = r_rptr;
        n_wptr = r_wptr;
        if (accept) begin
            if (!is_read) begin
                n_mods = upd.mods;
            end
            if (do_pop) begin
                n_rptr = ptr_inc(r_rptr);
            end
            if (do_push) begin
                n_wptr = ptr_inc(r_wptr);
            end
        end
    end

    // Queue RAM: write on push, registered read on pop.
    always_ff @(posedge i_clk) begin
        if (accept && do_push) begin
            r_store[r_wptr] <= upd.ch;
        end
        if (accept && do_pop) begin
            r_rd_data <= r_store[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods      <= '0;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mods <= n_mods;
            r_rptr <= n_rptr;
            r_wptr <= n_wptr;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop      <= do_pop;
            r_s1_nonempty <= (n_rptr != n_wptr);
            r_s1_mods     <= n_mods;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_user <= r_s1_pop;
            r_out_data <= {5'b0, r_s1_mods.alt, r_s1_mods.ctrl, r_s1_mods.shift,
                           r_s1_nonempty, r_s1_pop ? r_rd_data : CHAR_W'(0)};
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_user;

endmodule

`default_nettype wire

// ===== sv/sc2a_keymap.sv =====
// Scancode decoder: modifier tracking and character lookup.
`default_nettype none

module sc2a_keymap (
    input  wire logic [7:0]       i_scancode,
    input  wire sc2a_pkg::t_mods  i_mods,
    output sc2a_pkg::t_key_upd    o_upd
);
    import sc2a_pkg::*;

    logic              rel;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] ch;

    assign rel  = i_scancode[7];
    assign code = i_scancode[CODE_W-1:0];
    assign ch   = key_char(code, i_mods.shift ^ i_mods.caps);

    always_comb begin
        o_upd.mods = i_mods;
        o_upd.push = 1'b0;
        o_upd.ch   = ch;
        priority if (code == SC_SHIFT_L || code == SC_SHIFT_R) begin
            o_upd.mods.shift = !rel;
        end else if (code == SC_CTRL) begin
            o_upd.mods.ctrl = !rel;
        end else if (code == SC_ALT) begin
            o_upd.mods.alt = !rel;
        end else if (code == SC_CAPS_LOCK) begin
            // toggle on press, drop release
            if (!rel) begin
                o_upd.mods.caps = !i_mods.caps;
            end
        end else begin
            o_upd.push = !rel && (ch != '0);
        end
    end

endmodule

`default_nettype wire
